>>> rtl/core/fmtb_pkg.sv
// fmtb_pkg: shared types, widths and codes of the fast marching tree builder
// no dependencies; imported by every module of the block
package fmtb_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DIMENSIONS = 3;
    localparam int COORD_BITS = 16;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DIM_W   = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int COST_W  = 24;
    localparam int RAD_W   = 16;
    localparam int SUM_X   = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 0;
    localparam int SUM_W   = 2 * COORD_BITS + SUM_X + (SUM_X % 2);
    localparam int ROOT_W  = SUM_W / 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(256);

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_LIM_EN = 2'd2;

    typedef enum logic [1:0] {
        ST_UNVISITED = 2'd0,
        ST_OPEN      = 2'd1,
        ST_CLOSED    = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_0;
        logic signed [COORD_BITS-1:0] coord_1;
        logic signed [COORD_BITS-1:0] coord_2;
        logic                         last_point;
    } t_point_word;

    typedef struct packed {
        logic [IDX_W-1:0]  point_index;
        logic              has_parent;
        logic [IDX_W-1:0]  parent_index;
        logic [COST_W-1:0] path_cost;
        logic [1:0]        node_status;
        logic              last_result;
    } t_result_word;

    typedef logic [DIMENSIONS-1:0][COORD_BITS-1:0] t_coords;

    typedef struct packed {
        logic              has_parent;
        logic [IDX_W-1:0]  parent;
        logic [COST_W-1:0] cost;
        t_status           status;
    } t_node;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIND_INIT,
        OP_FIND_CHK,
        OP_ZP_LD,
        OP_X_CHK,
        OP_ACC_XZ,
        OP_Y_INIT,
        OP_Y_RD,
        OP_Y_CHK,
        OP_ACC_XY,
        OP_SQ_START,
        OP_Y_CMP,
        OP_Y_INC,
        OP_X_WR,
        OP_X_INC,
        OP_R_END,
        OP_E_INIT,
        OP_E_OUT,
        OP_CLEAR,
        OP_ZP_RD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic busy;
    } t_cmd;

    typedef struct packed {
        logic x_last;
        logic y_last;
        logic z_found;
        logic x_cand;
        logic y_open;
        logic dim_last;
        logic in_rad;
        logic sq_busy;
        logic stop;
    } t_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_INIT,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIND_DONE,
        S_ZP_LD,
        S_X_RD,
        S_X_CHK,
        S_XZ_ACC,
        S_XZ_TST,
        S_Y_RD,
        S_Y_CHK,
        S_YD_ACC,
        S_YD_TST,
        S_Y_SQ,
        S_Y_CMP,
        S_Y_NEXT,
        S_X_WR,
        S_X_NEXT,
        S_R_END,
        S_E_INIT,
        S_E_RD,
        S_E_OUT,
        S_CLEAR
    } t_state;

endpackage

>>> rtl/core/fmtb_isqrt.sv
// fmtb_isqrt: iterative integer square root, one result bit per cycle
// depends on fmtb_pkg
module fmtb_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fmtb_pkg::SUM_W-1:0]  i_value,
    output logic [fmtb_pkg::ROOT_W-1:0] o_root,
    output logic                        o_busy
);
    import fmtb_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [SUM_W-1:0]  r_n;
    logic [SUM_W:0]    r_res;
    logic [SUM_W-1:0]  r_bit;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W:0]    trial;

    assign trial = r_res + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= STEP_W'(ROOT_W);
        end else if (r_step != '0) begin
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_value;
            r_res <= '0;
            r_bit <= SUM_W'(1) << (SUM_W - 2);
        end else if (r_step != '0) begin
            if ({1'b0, r_n} >= trial) begin
                r_n   <= r_n - trial[SUM_W-1:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[ROOT_W-1:0];
    assign o_busy = (r_step != '0);

endmodule

>>> rtl/core/fmtb_ctrl.sv
// fmtb_ctrl: sequencer for loading, tree growth rounds and result emission
// depends on fmtb_pkg
module fmtb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_last_point,
    input  fmtb_pkg::t_stat i_stat,
    output fmtb_pkg::t_cmd  o_cmd
);
    import fmtb_pkg::*;

    t_state r_state;
    t_state n_state;
    t_op    op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op = OP_LOAD;
                    if (i_last_point) n_state = S_FIND_INIT;
                end
            end
            S_FIND_INIT: begin
                op      = OP_FIND_INIT;
                n_state = S_FIND_RD;
            end
            S_FIND_RD: n_state = S_FIND_CHK;
            S_FIND_CHK: begin
                op      = OP_FIND_CHK;
                n_state = i_stat.x_last ? S_FIND_DONE : S_FIND_RD;
            end
            S_FIND_DONE: begin
                if (i_stat.z_found) begin
                    op      = OP_ZP_RD;
                    n_state = S_ZP_LD;
                end else begin
                    n_state = S_E_INIT;
                end
            end
            S_ZP_LD: begin
                op      = OP_ZP_LD;
                n_state = S_X_RD;
            end
            S_X_RD: n_state = S_X_CHK;
            S_X_CHK: begin
                op      = OP_X_CHK;
                n_state = i_stat.x_cand ? S_XZ_ACC : S_X_NEXT;
            end
            S_XZ_ACC: begin
                op = OP_ACC_XZ;
                if (i_stat.dim_last) n_state = S_XZ_TST;
            end
            S_XZ_TST: begin
                if (i_stat.in_rad) begin
                    op      = OP_Y_INIT;
                    n_state = S_Y_RD;
                end else begin
                    n_state = S_X_NEXT;
                end
            end
            S_Y_RD: begin
                op      = OP_Y_RD;
                n_state = S_Y_CHK;
            end
            S_Y_CHK: begin
                op      = OP_Y_CHK;
                n_state = i_stat.y_open ? S_YD_ACC : S_Y_NEXT;
            end
            S_YD_ACC: begin
                op = OP_ACC_XY;
                if (i_stat.dim_last) n_state = S_YD_TST;
            end
            S_YD_TST: begin
                if (i_stat.in_rad) begin
                    op      = OP_SQ_START;
                    n_state = S_Y_SQ;
                end else begin
                    n_state = S_Y_NEXT;
                end
            end
            S_Y_SQ: begin
                if (!i_stat.sq_busy) n_state = S_Y_CMP;
            end
            S_Y_CMP: begin
                op      = OP_Y_CMP;
                n_state = S_Y_NEXT;
            end
            S_Y_NEXT: begin
                if (i_stat.y_last) begin
                    n_state = S_X_WR;
                end else begin
                    op      = OP_Y_INC;
                    n_state = S_Y_RD;
                end
            end
            S_X_WR: begin
                op      = OP_X_WR;
                n_state = S_X_NEXT;
            end
            S_X_NEXT: begin
                if (i_stat.x_last) begin
                    n_state = S_R_END;
                end else begin
                    op      = OP_X_INC;
                    n_state = S_X_RD;
                end
            end
            S_R_END: begin
                op      = OP_R_END;
                n_state = i_stat.stop ? S_E_INIT : S_FIND_INIT;
            end
            S_E_INIT: begin
                op      = OP_E_INIT;
                n_state = S_E_RD;
            end
            S_E_RD: n_state = S_E_OUT;
            S_E_OUT: begin
                op      = OP_E_OUT;
                n_state = i_stat.x_last ? S_CLEAR : S_E_RD;
            end
            S_CLEAR: begin
                op      = OP_CLEAR;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op   = op;
    assign o_cmd.busy = (r_state != S_IDLE);

endmodule

>>> rtl/core/fmtb_dp.sv
// fmtb_dp: point and node memories, indices, distance accumulator and result register
// depends on fmtb_pkg and fmtb_isqrt
module fmtb_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fmtb_pkg::t_cmd               i_cmd,
    input  fmtb_pkg::t_point_word        i_point,
    input  logic [fmtb_pkg::RAD_W-1:0]   i_radius,
    input  logic [fmtb_pkg::COST_W-1:0]  i_limit,
    input  logic                         i_lim_en,
    output fmtb_pkg::t_stat              o_stat,
    output fmtb_pkg::t_result_word       o_result,
    output logic                         o_result_strobe
);
    import fmtb_pkg::*;

    localparam t_node NODE_RESET = '{has_parent: 1'b0, parent: '0,
                                     cost: COST_MAX, status: ST_UNVISITED};

    t_coords            r_pmem [MAX_POINTS];
    t_node              r_nmem [MAX_POINTS];
    t_coords            r_prd;
    t_node              r_nrd;
    logic               r_nv;
    logic [MAX_POINTS-1:0] r_valid;
    logic [MAX_POINTS-1:0] r_fresh;

    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_xi, r_yi, r_zi;
    logic               r_zfound;
    logic [COST_W-1:0]  r_zcost;
    logic               r_zhp;
    logic [IDX_W-1:0]   r_zpar;
    t_coords            r_pz, r_px, r_py;
    logic [SUM_W-1:0]   r_sum;
    logic [DIM_W-1:0]   r_dim;
    logic [2*RAD_W-1:0] r_r2;
    logic [COST_W-1:0]  r_ycost;
    logic               r_have;
    logic [IDX_W-1:0]   r_best;
    logic [COST_W-1:0]  r_bestc;
    logic [COST_W-1:0]  r_largest;

    t_node                     nd;
    logic [IDX_W-1:0]          rd_addr;
    logic                      nwe;
    logic [IDX_W-1:0]          nwa;
    t_node                     nwd;
    logic [IDX_W-1:0]          last_idx;
    logic signed [COORD_BITS-1:0] ca, cb;
    logic signed [COORD_BITS:0]   diff;
    logic [COORD_BITS:0]       mag;
    logic [2*COORD_BITS-1:0]   sq;
    logic [ROOT_W-1:0]         root;
    logic                      sq_busy;
    logic [COST_W:0]           csum;
    logic [COST_W-1:0]         cnew;
    t_coords                   in_c;

    fmtb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQ_START),
        .i_value (r_sum),
        .o_root  (root),
        .o_busy  (sq_busy)
    );

    // effective node: unwritten entries read as their reset value
    assign nd       = r_nv ? r_nrd : NODE_RESET;
    assign last_idx = IDX_W'(r_cnt - CNT_W'(1));

    always_comb begin
        case (i_cmd.op)
            OP_Y_RD: rd_addr = r_yi;
            OP_ZP_RD: rd_addr = r_zi;
            default: rd_addr = r_xi;
        endcase
    end

    assign in_c[0] = i_point.coord_0;
    assign in_c[1] = i_point.coord_1;
    assign in_c[2] = i_point.coord_2;

    // one squared coordinate difference per cycle
    assign ca   = r_px[r_dim];
    assign cb   = (i_cmd.op == OP_ACC_XZ) ? r_pz[r_dim] : r_py[r_dim];
    assign diff = {ca[COORD_BITS-1], ca} - {cb[COORD_BITS-1], cb};
    assign mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
    assign sq   = mag[COORD_BITS-1:0] * mag[COORD_BITS-1:0];

    assign csum = {1'b0, r_ycost} + (COST_W+1)'(root);
    assign cnew = csum[COST_W] ? COST_MAX : csum[COST_W-1:0];

    always_comb begin
        nwe = 1'b0;
        nwa = r_xi;
        nwd = NODE_RESET;
        case (i_cmd.op)
            OP_LOAD: begin
                nwe = (r_cnt == '0);
                nwa = '0;
                nwd = '{has_parent: 1'b0, parent: '0, cost: '0, status: ST_OPEN};
            end
            OP_X_WR: begin
                nwe = r_have;
                nwd = '{has_parent: 1'b1, parent: r_best, cost: r_bestc,
                        status: ST_OPEN};
            end
            OP_R_END: begin
                nwe = 1'b1;
                nwa = r_zi;
                nwd = '{has_parent: r_zhp, parent: r_zpar, cost: r_zcost,
                        status: ST_CLOSED};
            end
            default: nwe = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && r_cnt < CNT_W'(MAX_POINTS)) begin
            r_pmem[r_cnt[IDX_W-1:0]] <= in_c;
        end
        if (nwe) r_nmem[nwa] <= nwd;
        r_prd <= r_pmem[rd_addr];
        r_nrd <= r_nmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_fresh         <= '0;
            r_cnt           <= '0;
            r_largest       <= '0;
            r_nv            <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            r_nv            <= r_valid[rd_addr];
            o_result_strobe <= (i_cmd.op == OP_E_OUT);
            if (nwe) r_valid[nwa] <= 1'b1;
            case (i_cmd.op)
                OP_LOAD: begin
                    if (r_cnt < CNT_W'(MAX_POINTS)) r_cnt <= r_cnt + CNT_W'(1);
                end
                OP_X_WR: begin
                    if (r_have) begin
                        r_fresh[r_xi] <= 1'b1;
                        if (r_bestc > r_largest) r_largest <= r_bestc;
                    end
                end
                OP_R_END: r_fresh <= '0;
                OP_CLEAR: begin
                    r_valid   <= '0;
                    r_fresh   <= '0;
                    r_cnt     <= '0;
                    r_largest <= '0;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= i_radius * i_radius;
        case (i_cmd.op)
            OP_FIND_INIT: begin
                r_xi     <= '0;
                r_zfound <= 1'b0;
            end
            OP_FIND_CHK: begin
                if (nd.status == ST_OPEN && (!r_zfound || nd.cost < r_zcost)) begin
                    r_zi     <= r_xi;
                    r_zcost  <= nd.cost;
                    r_zhp    <= nd.has_parent;
                    r_zpar   <= nd.parent;
                    r_zfound <= 1'b1;
                end
                r_xi <= r_xi + IDX_W'(1);
            end
            OP_ZP_LD: begin
                r_pz <= r_prd;
                r_xi <= '0;
            end
            OP_X_CHK: begin
                r_px  <= r_prd;
                r_sum <= '0;
                r_dim <= '0;
            end
            OP_ACC_XZ, OP_ACC_XY: begin
                r_sum <= r_sum + SUM_W'(sq);
                r_dim <= r_dim + DIM_W'(1);
            end
            OP_Y_INIT: begin
                r_yi   <= '0;
                r_have <= 1'b0;
            end
            OP_Y_CHK: begin
                r_py    <= r_prd;
                r_ycost <= nd.cost;
                r_sum   <= '0;
                r_dim   <= '0;
            end
            OP_Y_CMP: begin
                if (!r_have || cnew < r_bestc) begin
                    r_have  <= 1'b1;
                    r_best  <= r_yi;
                    r_bestc <= cnew;
                end
            end
            OP_Y_INC: r_yi <= r_yi + IDX_W'(1);
            OP_X_INC: r_xi <= r_xi + IDX_W'(1);
            OP_E_INIT: r_xi <= '0;
            OP_E_OUT: begin
                o_result.point_index  <= r_xi;
                o_result.has_parent   <= nd.has_parent;
                o_result.parent_index <= nd.has_parent ? nd.parent : '0;
                o_result.path_cost    <= nd.cost;
                o_result.node_status  <= nd.status;
                o_result.last_result  <= (r_xi == last_idx);
                r_xi <= r_xi + IDX_W'(1);
            end
            default: r_dim <= r_dim;
        endcase
    end

    assign o_stat.x_last   = (r_xi == last_idx);
    assign o_stat.y_last   = (r_yi == last_idx);
    assign o_stat.z_found  = r_zfound;
    assign o_stat.x_cand   = (nd.status == ST_UNVISITED) && !r_fresh[r_xi];
    assign o_stat.y_open   = (nd.status == ST_OPEN) && !r_fresh[r_yi];
    assign o_stat.dim_last = (r_dim == DIM_W'(DIMENSIONS - 1));
    assign o_stat.in_rad   = (r_sum < SUM_W'(r_r2));
    assign o_stat.sq_busy  = sq_busy;
    assign o_stat.stop     = i_lim_en && (r_largest > i_limit);

endmodule

>>> rtl/core/fast_marching_tree_builder.sv
// fast_marching_tree_builder: top level, configuration registers and APB port
// depends on fmtb_pkg, fmtb_ctrl, fmtb_dp
//
// Points are loaded one word per start pulse (start taken while busy is low);
// point 0 is the root. A word with last_point set starts tree growth and busy
// stays high until all results are out. Growth runs round by round: a scan
// over all n nodes picks the open node of least cost, then each candidate
// point is tested against it and, when inside the radius, against every node
// open at the start of the round; each test is one multiply-accumulate per
// dimension, and a test against an open node inside the radius adds a square
// root wait. Growth time is set by the single shared distance unit and the
// memories with their single read port. Then one result word per loaded point
// is strobed on o_result_strobe, each read from the node memory before it is
// sent; the receiver cannot hold results off. Configuration must be written
// while busy is low.
module fast_marching_tree_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fmtb_pkg::t_point_word            i_point,
    output fmtb_pkg::t_result_word           o_result,
    output logic                             o_result_strobe,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fmtb_pkg::ADDR_W-1:0]      paddr,
    input  logic [fmtb_pkg::DATA_W-1:0]      pwdata,
    output logic [fmtb_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import fmtb_pkg::*;

    logic [RAD_W-1:0]  r_radius;
    logic [COST_W-1:0] r_limit;
    logic              r_lim_en;
    t_cmd              cmd;
    t_stat             stat;

    // configuration registers, written in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_limit  <= COST_MAX;
            r_lim_en <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_LIMIT:  r_limit  <= pwdata[COST_W-1:0];
                REG_LIM_EN: r_lim_en <= pwdata[0];
                default:    r_lim_en <= r_lim_en;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = DATA_W'(r_radius);
            REG_LIMIT:  prdata = DATA_W'(r_limit);
            REG_LIM_EN: prdata = DATA_W'(r_lim_en);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    fmtb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_point (i_point.last_point),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // memories and arithmetic
    fmtb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_point         (i_point),
        .i_radius        (r_radius),
        .i_limit         (r_limit),
        .i_lim_en        (r_lim_en),
        .o_stat          (stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

    assign busy = cmd.busy;

endmodule

>>> rtl/core/fmtb_checker.sv
// fmtb_checker: port-level temporal checks of the tree builder, bound to the top
// depends on fmtb_pkg and fast_marching_tree_builder
module fmtb_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input fmtb_pkg::t_point_word   i_point,
    input fmtb_pkg::t_result_word  o_result,
    input logic                    o_result_strobe
);
    import fmtb_pkg::*;

    // results only appear while a cloud is being processed
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy) else $error("result outside busy");

    // a non-final word is absorbed without raising busy
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_point.last_point) |=> !busy)
        else $error("load did not return idle");

    // a final word starts growth
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_point.last_point) |=> busy)
        else $error("growth not started");

    // result words are never back to back
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("results back to back");

    // the final result word ends the busy period
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last_result) |=> !busy)
        else $error("busy after last result");

endmodule

bind fast_marching_tree_builder fmtb_checker u_fmtb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_point         (i_point),
    .o_result        (o_result),
    .o_result_strobe (o_result_strobe)
);
